/* hdl/hrt_pkg.sv */
// Shared types and constants for the HTTP request tokenizer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package hrt_pkg;

    // Byte codes that steer the tokenizer.
    localparam logic [7:0] ByteCr    = 8'h0D;
    localparam logic [7:0] ByteLf    = 8'h0A;
    localparam logic [7:0] ByteSp    = 8'h20;
    localparam logic [7:0] ByteTab   = 8'h09;
    localparam logic [7:0] ByteVt    = 8'h0B;
    localparam logic [7:0] ByteFf    = 8'h0C;
    localparam logic [7:0] ByteColon = 8'h3A;

    // Only the first three request-line tokens are passed on.
    localparam logic [1:0] TokLimit = 2'd3;

    // Largest number of results one input byte can cause.
    localparam int MaxRes = 3;

    typedef enum logic [1:0] {
        PH_REQ   = 2'd0,
        PH_NAME  = 2'd1,
        PH_VALUE = 2'd2,
        PH_BODY  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        KIND_METHOD  = 3'd0,
        KIND_URL     = 3'd1,
        KIND_VERSION = 3'd2,
        KIND_NAME    = 3'd3,
        KIND_VALUE   = 3'd4,
        KIND_BODY    = 3'd5,
        KIND_END     = 3'd6
    } t_kind;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic       first;
        logic [4:0] hidx;
        logic       ovf;
        logic       last;
    } t_result;

    // All results of one input byte, oldest in entry 0.
    typedef struct packed {
        logic [1:0]               count;
        t_result [MaxRes-1:0]     res;
    } t_batch;

endpackage

/* hdl/hrt_parse.sv */
// Tokenizer state and the per-byte step logic that turns one byte into its results.
// Depends on hrt_pkg.
`timescale 1ns / 1ps

module hrt_parse #(
    parameter int MAX_HEADERS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_byte,
    input  logic            i_eor,
    output hrt_pkg::t_batch o_batch
);
    import hrt_pkg::*;

    localparam int         HdrCapInt = (MAX_HEADERS < 31) ? MAX_HEADERS : 31;
    localparam logic [4:0] HdrCap    = 5'(HdrCapInt);

    t_phase     r_phase,  n_phase;
    logic [1:0] r_tok,    n_tok;
    logic       r_inside, n_inside;
    logic       r_lf,     n_lf;
    logic       r_colon,  n_colon;
    logic       r_begun,  n_begun;
    logic [4:0] r_hcnt,   n_hcnt;
    logic       r_ovf,    n_ovf;

    // Events found by the next-state logic, used to build the result list.
    logic       e_held, e_held_first;
    logic       e_main, e_main_first;
    t_kind      e_kind;
    logic       e_eor_colon, e_eor_first;
    logic [4:0] m_hcnt, f_hcnt;
    logic       m_ovf,  f_ovf;

    // Header count with saturation; the top bit is the overflow flag.
    function automatic logic [5:0] f_count(input logic [5:0] v);
        logic [5:0] r;
        r = v;
        if (v[4:0] < HdrCap) begin
            r[4:0] = v[4:0] + 5'd1;
        end else begin
            r[5] = 1'b1;
        end
        return r;
    endfunction

    function automatic logic f_is_sep(input logic [7:0] b);
        return (b == ByteSp) || (b == ByteTab) || (b == ByteLf) ||
               (b == ByteVt) || (b == ByteFf);
    endfunction

    always_comb begin
        t_phase     ph;
        logic [1:0] tn;
        logic       it, ch, fb, ov, nl, drop, skip;
        logic [4:0] hc;
        ph = r_phase;
        tn = r_tok;
        it = r_inside;
        ch = r_colon;
        fb = r_begun;
        hc = r_hcnt;
        ov = r_ovf;
        nl = 1'b0;
        skip = 1'b0;
        e_held = 1'b0;
        e_held_first = 1'b0;
        e_main = 1'b0;
        e_main_first = 1'b0;
        e_kind = KIND_METHOD;
        e_eor_colon = 1'b0;
        e_eor_first = 1'b0;
        // A single LF right after a CR is swallowed.
        drop = r_lf && (i_byte == ByteLf);
        if (!drop) begin
            unique case (r_phase)
                PH_REQ: begin
                    if (i_byte == ByteCr) begin
                        ph = PH_NAME;
                        it = 1'b0;
                        fb = 1'b0;
                        nl = 1'b1;
                    end else if (f_is_sep(i_byte)) begin
                        if (it) begin
                            it = 1'b0;
                            if (tn < TokLimit) begin
                                tn = tn + 2'd1;
                            end
                        end
                    end else begin
                        if (tn < TokLimit) begin
                            e_main = 1'b1;
                            e_kind = t_kind'({1'b0, tn});
                            e_main_first = !it;
                        end
                        it = 1'b1;
                    end
                end
                PH_NAME: begin
                    if (ch) begin
                        ch = 1'b0;
                        if (i_byte == ByteSp) begin
                            ph = PH_VALUE;
                            fb = 1'b0;
                            skip = 1'b1;
                        end else begin
                            e_held = 1'b1;
                            e_held_first = !fb;
                            fb = 1'b1;
                        end
                    end
                    if (!skip) begin
                        if (i_byte == ByteCr) begin
                            if (fb) begin
                                {ov, hc} = f_count({ov, hc});
                            end else begin
                                ph = PH_BODY;
                            end
                            fb = 1'b0;
                            nl = 1'b1;
                        end else if (i_byte == ByteColon) begin
                            ch = 1'b1;
                        end else begin
                            e_main = 1'b1;
                            e_kind = KIND_NAME;
                            e_main_first = !fb;
                            fb = 1'b1;
                        end
                    end
                end
                PH_VALUE: begin
                    if (i_byte == ByteCr) begin
                        {ov, hc} = f_count({ov, hc});
                        ph = PH_NAME;
                        fb = 1'b0;
                        nl = 1'b1;
                    end else begin
                        e_main = 1'b1;
                        e_kind = KIND_VALUE;
                        e_main_first = !fb;
                        fb = 1'b1;
                    end
                end
                PH_BODY: begin
                    e_main = 1'b1;
                    e_kind = KIND_BODY;
                    e_main_first = !fb;
                    fb = 1'b1;
                end
            endcase
        end
        m_hcnt = hc;
        m_ovf = ov;
        if (i_eor) begin
            if (ch) begin
                e_eor_colon = 1'b1;
                e_eor_first = !fb;
                fb = 1'b1;
            end
            if ((ph == PH_VALUE) || ((ph == PH_NAME) && fb)) begin
                {ov, hc} = f_count({ov, hc});
            end
        end
        f_hcnt = hc;
        f_ovf = ov;
        if (i_eor) begin
            n_phase = PH_REQ;
            n_tok = 2'd0;
            n_inside = 1'b0;
            n_lf = 1'b0;
            n_colon = 1'b0;
            n_begun = 1'b0;
            n_hcnt = 5'd0;
            n_ovf = 1'b0;
        end else begin
            n_phase = ph;
            n_tok = tn;
            n_inside = it;
            n_lf = nl;
            n_colon = ch;
            n_begun = fb;
            n_hcnt = hc;
            n_ovf = ov;
        end
    end

    // Result list: held colon, content byte, colon held at end, end marker.
    always_comb begin
        logic [1:0] idx;
        idx = 2'd0;
        o_batch = '0;
        if (e_held) begin
            o_batch.res[idx] = '{data: ByteColon, kind: KIND_NAME, first: e_held_first,
                                 hidx: r_hcnt, ovf: r_ovf, last: 1'b0};
            idx = idx + 2'd1;
        end
        if (e_main) begin
            o_batch.res[idx] = '{data: i_byte, kind: e_kind, first: e_main_first,
                                 hidx: r_hcnt, ovf: r_ovf, last: 1'b0};
            idx = idx + 2'd1;
        end
        if (e_eor_colon) begin
            o_batch.res[idx] = '{data: ByteColon, kind: KIND_NAME, first: e_eor_first,
                                 hidx: m_hcnt, ovf: m_ovf, last: 1'b0};
            idx = idx + 2'd1;
        end
        if (i_eor) begin
            o_batch.res[idx] = '{data: 8'd0, kind: KIND_END, first: 1'b0,
                                 hidx: f_hcnt, ovf: f_ovf, last: 1'b0};
            idx = idx + 2'd1;
        end
        if (idx != 2'd0) begin
            o_batch.res[2'(idx - 2'd1)].last = 1'b1;
        end
        o_batch.count = idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_REQ;
            r_tok    <= 2'd0;
            r_inside <= 1'b0;
            r_lf     <= 1'b0;
            r_colon  <= 1'b0;
            r_begun  <= 1'b0;
            r_hcnt   <= 5'd0;
            r_ovf    <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_tok    <= n_tok;
            r_inside <= n_inside;
            r_lf     <= n_lf;
            r_colon  <= n_colon;
            r_begun  <= n_begun;
            r_hcnt   <= n_hcnt;
            r_ovf    <= n_ovf;
        end
    end

endmodule

/* hdl/hrt_outq.sv */
// Result register for the tokenizer: holds the up to three results of one byte
// and hands them out one beat at a time. Depends on hrt_pkg.
`timescale 1ns / 1ps

module hrt_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hrt_pkg::t_batch  i_batch,
    input  logic             i_stall,
    output logic             o_ready,
    output logic             o_valid,
    output hrt_pkg::t_result o_head
);
    import hrt_pkg::*;

    t_result    r_q [MaxRes];
    logic [1:0] r_count;
    logic       pop;

    assign o_valid = (r_count != 2'd0);
    assign pop     = o_valid && !i_stall;
    // A new batch may load once the register is empty or its last beat leaves now.
    assign o_ready = (r_count == 2'd0) || ((r_count == 2'd1) && pop);
    assign o_head  = r_q[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (i_push) begin
            r_count <= i_batch.count;
        end else if (pop) begin
            r_count <= r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            for (int k = 0; k < MaxRes; k++) begin
                r_q[k] <= i_batch.res[k];
            end
        end else if (pop) begin
            for (int k = 0; k < MaxRes - 1; k++) begin
                r_q[k] <= r_q[k+1];
            end
        end
    end

endmodule

/* hdl/http_request_tokenizer.sv */
// Path: a byte is registered on acceptance, then its results are loaded into the result register.
// Throughput: one byte per cycle while each byte yields at most one result and the output is
// not stalled; a byte that yields two or three results (held colon, end marker) holds the input
// until its last result leaves, as the single result register drains one beat per unstalled cycle.
// Reset: synchronous, active low; clears the tokenizer state and both valid flags.
// Top level of the HTTP request tokenizer; uses hrt_pkg, hrt_parse and hrt_outq.
`timescale 1ns / 1ps

module http_request_tokenizer #(
    parameter int MAX_HEADERS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input channel: one raw request byte per beat.
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_request,
    // Output channel: one tagged content byte or end marker per beat.
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_field_kind,
    output logic       o_field_first,
    output logic [4:0] o_header_index,
    output logic       o_header_overflow,
    output logic       o_run_last
);
    import hrt_pkg::*;

    localparam int         HdrCapInt = (MAX_HEADERS < 31) ? MAX_HEADERS : 31;
    localparam logic [4:0] HdrCap    = 5'(HdrCapInt);

    // Input register. It is loaded whenever it is empty or its byte is being
    // consumed, so a fresh byte can follow in the very next cycle.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eor;
    logic       accept;
    logic       consume;
    logic       q_ready;
    t_batch     batch;
    t_result    head;

    // The registered byte is processed when the result register can take all
    // of its results in one go.
    assign consume = r_in_valid && q_ready;
    assign o_stall = r_in_valid && !consume;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in_byte;
            r_in_eor  <= i_end_of_request;
        end
    end

    // The step logic updates the tokenizer state and builds the result list
    // for the registered byte in the same cycle.
    hrt_parse #(
        .MAX_HEADERS(MAX_HEADERS)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (consume),
        .i_byte  (r_in_byte),
        .i_eor   (r_in_eor),
        .o_batch (batch)
    );

    // The result register holds the list and presents its head.
    hrt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (consume),
        .i_batch (batch),
        .i_stall (i_stall),
        .o_ready (q_ready),
        .o_valid (o_valid),
        .o_head  (head)
    );

    assign o_out_byte        = head.data;
    assign o_field_kind      = head.kind;
    assign o_field_first     = head.first;
    assign o_header_index    = head.hidx;
    assign o_header_overflow = head.ovf;
    assign o_run_last        = head.last;

    // The end marker is always the final beat of its byte and carries no content.
    a_end_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_field_kind == KIND_END)) |-> (o_run_last && !o_field_first &&
                                                     (o_out_byte == 8'd0)))
        else $error("end marker is not a clean final beat");

    // The header index never passes its saturation point.
    a_hidx_cap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_header_index <= HdrCap))
        else $error("header index beyond its cap");

    // A byte waiting in the input register stays put until it is processed.
    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !consume) |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_eor)))
        else $error("waiting input byte lost or changed");

    // A new byte is never processed while earlier results still wait behind the head.
    a_no_overrun : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume |-> (!o_valid || (o_run_last && !i_stall)))
        else $error("results of a byte overwritten before delivery");

endmodule
